>>> src/atmcal_pkg.sv
// Shared constants, types and helper functions for the trimmed-mean ADC calibration unit.
`default_nettype none

package atmcal_pkg;

  // Block sizing
  localparam int WINDOW   = 8;
  localparam int CHANNELS = 16;
  localparam int TRIM     = 2;

  // Fixed field widths
  localparam int IN_CH_W = 4;
  localparam int SMP_W   = 12;
  localparam int SUM_W   = 18;
  localparam int CNT_W   = 6;
  localparam int FLD_W   = 3;
  localparam int WORD_W  = 32;
  localparam int CAL_W   = 31;

  // Storage geometry
  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CAL_FIELDS = 1 << FLD_W;
  localparam int CAL_DEPTH  = CHANNELS * CAL_FIELDS;
  localparam int CAL_AW     = CH_AW + FLD_W;

  localparam logic [IN_CH_W:0] CH_LIMIT = (IN_CH_W + 1)'(CHANNELS);
  localparam logic [CNT_W:0]   WIN_CNT  = (CNT_W + 1)'(WINDOW);

  // Divide by WINDOW-TRIM as multiply by reciprocal plus one correction step
  localparam int                   RECIP_SHIFT = 24;
  localparam int                   PROD_W      = SUM_W + RECIP_SHIFT + 1;
  localparam logic [SUM_W-1:0]     DIV_C       = SUM_W'(WINDOW - TRIM);
  localparam logic [RECIP_SHIFT:0] RECIP       =
    (RECIP_SHIFT + 1)'((64'd1 << RECIP_SHIFT) / (WINDOW - TRIM));

  // Calibration datapath widths
  localparam int MUL_W  = SMP_W + 1 + WORD_W + 1;  // mean times 33-bit signed operand
  localparam int DVD_W  = MUL_W - 1;               // dividend magnitude
  localparam int DVS_W  = WORD_W + 1;              // divisor magnitude
  localparam int STEP_W = $clog2(DVD_W + 1);
  localparam int WIDE_W = 49;                      // clamp input

  // Request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CAL    = 1'b1;

  // Calibration field codes
  localparam logic [FLD_W-1:0] FLD_MODE   = 3'd0;
  localparam logic [FLD_W-1:0] FLD_XLOW   = 3'd1;
  localparam logic [FLD_W-1:0] FLD_XHIGH  = 3'd2;
  localparam logic [FLD_W-1:0] FLD_YLOW   = 3'd3;
  localparam logic [FLD_W-1:0] FLD_YHIGH  = 3'd4;
  localparam logic [FLD_W-1:0] FLD_GAIN   = 3'd5;
  localparam logic [FLD_W-1:0] FLD_OFFSET = 3'd6;
  localparam logic [FLD_W-1:0] FLD_UNUSED = 3'd7;

  // Calibration modes
  localparam logic [1:0] MODE_RAW       = 2'd0;
  localparam logic [1:0] MODE_TWO_POINT = 2'd1;
  localparam logic [1:0] MODE_GAIN      = 2'd2;

  localparam logic [SMP_W-1:0]  SMP_MAX    = '1;
  localparam logic [WORD_W-1:0] GAIN_UNITY = 32'h0001_0000;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SMP_W-1:0] min;
    logic [SMP_W-1:0] max;
    logic [CNT_W-1:0] count;
  } acc_entry_t;

  localparam acc_entry_t ACC_RESET = '{sum: '0, min: SMP_MAX, max: '0, count: '0};

  function automatic logic [WORD_W-1:0] cal_reset_value(input logic [FLD_W-1:0] fld);
    return (fld == FLD_GAIN) ? GAIN_UNITY : '0;
  endfunction

  // Clamp a signed value to 0 .. 2^31-1
  function automatic logic [CAL_W-1:0] clamp31(input logic signed [WIDE_W-1:0] v);
    logic [CAL_W-1:0] res;
    if (v[WIDE_W-1]) begin
      res = '0;
    end else if (|v[WIDE_W-2:CAL_W]) begin
      res = '1;
    end else begin
      res = v[CAL_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/adc_trimmed_mean_calibrate_unit.sv
// Top level of the per-channel trimmed-mean ADC filter with calibration.
//
//  channel | direction | handshake               | payload
//  in_     | input     | in_valid / in_stall     | req_type, channel, sample, cal_field, cal_word
//  out_    | output    | out_valid / out_stall   | out_channel, trimmed_mean, calibrated, div_error
//
// A calibration word write completes on acceptance. A sample that does not close its
// window takes an accumulator read, then a read-modify-write of the same entry.
// A sample that closes a window then fetches its calibration set, prepares, multiplies
// and evaluates; raw and gain mode, and two-point mode with equal x points, finish
// there; otherwise a radix-2 divider yields one quotient bit per cycle (45 bits),
// then the offset is added. The input reopens when the result is loaded.
// Synchronous active-low reset clears the per-entry valid bits, so every channel
// reads its reset accumulator and calibration set without a clearing pass.
// The result sits in an output register; a stalled result holds the block only
// when the next result is ready to be loaded.
`default_nettype none

module adc_trimmed_mean_calibrate_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // sample / calibration write channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_req_type,
  input  wire logic [atmcal_pkg::IN_CH_W-1:0] in_channel,
  input  wire logic [atmcal_pkg::SMP_W-1:0]   in_sample,
  input  wire logic [atmcal_pkg::FLD_W-1:0]   in_cal_field,
  input  wire logic [atmcal_pkg::WORD_W-1:0]  in_cal_word,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [atmcal_pkg::IN_CH_W-1:0]      out_channel,
  output logic [atmcal_pkg::SMP_W-1:0]        out_trimmed_mean,
  output logic [atmcal_pkg::CAL_W-1:0]        out_calibrated,
  output logic                                out_div_error
);

  import atmcal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_FETCH,
    S_PREP,
    S_MUL,
    S_EVAL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t state_r;

  // Item capture
  logic [CH_AW-1:0] ch_r;
  logic [SMP_W-1:0] smp_r;

  // Accumulator memory, one entry per channel, with reset-valid bits
  acc_entry_t       acc_mem [CHANNELS];
  logic [CHANNELS-1:0] acc_vld_r;
  acc_entry_t       acc_rdata_r;
  logic             acc_rvld_r;
  logic             acc_we;
  acc_entry_t       acc_cur;
  acc_entry_t       acc_nxt;
  logic             win_done;

  // Calibration memory, addressed by {channel, field}
  logic [WORD_W-1:0]    cal_mem [CAL_DEPTH];
  logic [CAL_DEPTH-1:0] cal_vld_r;
  logic [WORD_W-1:0]    cal_rdata_r;
  logic                 cal_rvld_r;
  logic                 cal_we;
  logic [CAL_AW-1:0]    cal_waddr;
  logic [WORD_W-1:0]    cal_wdata;
  logic [CAL_AW-1:0]    cal_raddr;
  logic [FLD_W-1:0]     fld_rd;
  logic [FLD_W-1:0]     fld_r;
  logic [WORD_W-1:0]    cal_word_eff;

  // Latched calibration set of the closing channel
  logic [1:0]        mode_r;
  logic [WORD_W-1:0] xl_r, xh_r, yl_r, yh_r, gain_r, off_r;

  // Trimmed mean: reciprocal multiply then correction
  logic [SUM_W-1:0]  diff_r;
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  q0;
  logic [SUM_W-1:0]  r0;
  logic              q_fix;
  logic [SUM_W-1:0]  rem_fix;
  logic [SUM_W-1:0]  mean_q;
  logic [SMP_W-1:0]  mean_r;

  // Calibration datapath
  logic signed [DVS_W-1:0]  den_r;
  logic signed [DVS_W-1:0]  dy_r;
  logic signed [DVS_W-1:0]  mul_b;
  logic signed [MUL_W-1:0]  prod2_r;
  logic signed [WIDE_W-1:0] t_gain;
  logic [MUL_W-1:0]         num_neg;
  logic [DVS_W-1:0]         den_neg;

  // Divider
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;
  logic [DVS_W:0]    rem_sh;
  logic              div_ge;
  logic [DVS_W:0]    rem_nxt;
  logic signed [MUL_W-1:0]  q_signed;
  logic signed [WIDE_W-1:0] q_plus_off;

  // Result staging and output register
  logic [CAL_W-1:0]   res_cal_r;
  logic               res_err_r;
  logic               out_valid_r;
  logic [IN_CH_W-1:0] out_channel_r;
  logic [SMP_W-1:0]   out_mean_r;
  logic [CAL_W-1:0]   out_cal_r;
  logic               out_err_r;

  // Input decode
  logic             in_acc;
  logic             ch_ok;
  logic [CH_AW-1:0] in_ch_idx;
  logic             take_sample;
  logic             load_out;

  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign ch_ok       = ({1'b0, in_channel} < CH_LIMIT);
  assign in_ch_idx   = in_channel[CH_AW-1:0];
  assign take_sample = in_acc && ch_ok && (in_req_type == REQ_SAMPLE);

  // Calibration writes complete on acceptance; drop unused field codes
  assign cal_we    = in_acc && ch_ok && (in_req_type == REQ_CAL) && (in_cal_field != FLD_UNUSED);
  assign cal_waddr = {in_ch_idx, in_cal_field};
  assign cal_wdata = (in_cal_field == FLD_MODE) ? {{(WORD_W-2){1'b0}}, in_cal_word[1:0]}
                                                : in_cal_word;

  // Sweep the calibration fields of the closing channel, mode first
  assign fld_rd    = (state_r == S_FETCH) ? fld_r + 1'b1 : FLD_MODE;
  assign cal_raddr = {ch_r, fld_rd};

  // An entry never written reads as its reset value
  assign cal_word_eff = cal_rvld_r ? cal_rdata_r : cal_reset_value(fld_r);

  // Accumulator update for the captured sample
  always_comb begin
    acc_cur       = acc_rvld_r ? acc_rdata_r : ACC_RESET;
    acc_nxt.sum   = acc_cur.sum + {{(SUM_W-SMP_W){1'b0}}, smp_r};
    acc_nxt.min   = (smp_r < acc_cur.min) ? smp_r : acc_cur.min;
    acc_nxt.max   = (smp_r > acc_cur.max) ? smp_r : acc_cur.max;
    acc_nxt.count = acc_cur.count + 1'b1;
  end

  assign win_done = ({1'b0, acc_nxt.count} >= WIN_CNT);
  assign acc_we   = (state_r == S_ACC) && !win_done;

  // Correct the reciprocal estimate by at most one
  assign q0      = prod_r[RECIP_SHIFT +: SUM_W];
  assign r0      = diff_r - SUM_W'(q0 * DIV_C);
  assign q_fix   = (r0 >= DIV_C);
  assign rem_fix = q_fix ? r0 - DIV_C : r0;
  assign mean_q  = q_fix ? q0 + 1'b1 : q0;

  // Share the multiplier between two-point slope and Q16.16 gain
  assign mul_b = (mode_r == MODE_TWO_POINT) ? dy_r : {gain_r[WORD_W-1], gain_r};

  assign t_gain = {{(WIDE_W-MUL_W){prod2_r[MUL_W-1]}}, prod2_r}
                + {off_r[WORD_W-1], off_r, 16'b0};

  assign num_neg = -prod2_r;
  assign den_neg = -den_r;

  // One restoring divide step per cycle
  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, dvs_r});
  assign rem_nxt = div_ge ? rem_sh - {1'b0, dvs_r} : rem_sh;

  assign q_signed   = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign q_plus_off = {{(WIDE_W-MUL_W){q_signed[MUL_W-1]}}, q_signed}
                    + {{(WIDE_W-WORD_W){off_r[WORD_W-1]}}, off_r};

  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Accumulator memory: write back, read at the incoming channel
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[ch_r] <= acc_nxt;
    end
    acc_rdata_r <= acc_mem[in_ch_idx];
    acc_rvld_r  <= acc_vld_r[in_ch_idx];
  end

  // Calibration memory: write on acceptance, read during the fetch sweep
  always_ff @(posedge clk) begin
    if (cal_we) begin
      cal_mem[cal_waddr] <= cal_wdata;
    end
    cal_rdata_r <= cal_mem[cal_raddr];
    cal_rvld_r  <= cal_vld_r[cal_raddr];
  end

  // Sequencer, valid bits, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_vld_r   <= '0;
      cal_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result, else drop the one just taken
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cal_we) begin
        cal_vld_r[cal_waddr] <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (take_sample) begin
            ch_r    <= in_ch_idx;
            smp_r   <= in_sample;
            state_r <= S_ACC;
          end
        end

        S_ACC: begin
          // Closing a window returns the entry to its reset values
          acc_vld_r[ch_r] <= !win_done;
          diff_r <= acc_nxt.sum - {{(SUM_W-SMP_W){1'b0}}, acc_nxt.min}
                                - {{(SUM_W-SMP_W){1'b0}}, acc_nxt.max};
          fld_r   <= FLD_MODE;
          state_r <= win_done ? S_FETCH : S_IDLE;
        end

        S_FETCH: begin
          prod_r <= diff_r * RECIP;
          mean_r <= mean_q[SMP_W-1:0];
          unique case (fld_r)
            FLD_MODE:   mode_r <= cal_word_eff[1:0];
            FLD_XLOW:   xl_r   <= cal_word_eff;
            FLD_XHIGH:  xh_r   <= cal_word_eff;
            FLD_YLOW:   yl_r   <= cal_word_eff;
            FLD_YHIGH:  yh_r   <= cal_word_eff;
            FLD_GAIN:   gain_r <= cal_word_eff;
            FLD_OFFSET: off_r  <= cal_word_eff;
            default:    ;
          endcase
          fld_r <= fld_r + 1'b1;
          if (fld_r == FLD_OFFSET) begin
            state_r <= S_PREP;
          end
        end

        S_PREP: begin
          den_r   <= $signed({xh_r[WORD_W-1], xh_r}) - $signed({xl_r[WORD_W-1], xl_r});
          dy_r    <= $signed({yh_r[WORD_W-1], yh_r}) - $signed({yl_r[WORD_W-1], yl_r});
          state_r <= S_MUL;
        end

        S_MUL: begin
          prod2_r <= $signed({1'b0, mean_r}) * mul_b;
          state_r <= S_EVAL;
        end

        S_EVAL: begin
          case (mode_r)
            MODE_TWO_POINT: begin
              if (den_r == '0) begin
                res_err_r <= 1'b1;
                res_cal_r <= '0;
                state_r   <= S_DONE;
              end else begin
                res_err_r <= 1'b0;
                quo_r   <= prod2_r[MUL_W-1] ? num_neg[DVD_W-1:0] : prod2_r[DVD_W-1:0];
                dvs_r   <= den_r[DVS_W-1] ? den_neg : den_r;
                neg_r   <= prod2_r[MUL_W-1] ^ den_r[DVS_W-1];
                rem_r   <= '0;
                step_r  <= STEP_W'(DVD_W);
                state_r <= S_DIV;
              end
            end
            MODE_GAIN: begin
              res_err_r <= 1'b0;
              res_cal_r <= clamp31(t_gain >>> 16);
              state_r   <= S_DONE;
            end
            default: begin
              res_err_r <= 1'b0;
              res_cal_r <= {{(CAL_W-SMP_W){1'b0}}, mean_r};
              state_r   <= S_DONE;
            end
          endcase
        end

        S_DIV: begin
          rem_r  <= rem_nxt[DVS_W-1:0];
          quo_r  <= {quo_r[DVD_W-2:0], div_ge};
          step_r <= step_r - 1'b1;
          if (step_r == STEP_W'(1)) begin
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          res_cal_r <= clamp31(q_plus_off);
          state_r   <= S_DONE;
        end

        S_DONE: begin
          // Hold until the output register is free
          if (load_out) begin
            out_channel_r <= IN_CH_W'(ch_r);
            out_mean_r    <= mean_r;
            out_cal_r     <= res_cal_r;
            out_err_r     <= res_err_r;
            state_r       <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_trimmed_mean = out_mean_r;
  assign out_calibrated   = out_cal_r;
  assign out_div_error    = out_err_r;

`ifndef SYNTH
  // A new result appears only out of the delivery state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside delivery state");

  // A flagged division error carries a zero calibrated value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_cal_r == '0))
    else $error("div_error with nonzero calibrated value");

  // The restoring divider keeps its partial remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dvs_r))
    else $error("divider remainder out of range");

  // The reciprocal estimate is off by at most one
  a_recip_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) |-> (rem_fix < DIV_C))
    else $error("trimmed mean correction insufficient");

  // Each window result starts its calibration sweep at the mode field
  a_fetch_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && win_done) |=> (state_r == S_FETCH && fld_r == FLD_MODE))
    else $error("calibration sweep did not start at mode field");
`endif

endmodule

`default_nettype wire
